// ===== rtl/urbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// urbfc_pkg: shared types and constants for the UART ring buffers
// Ring depths, pointer widths, operation and register codes, beat structs.
// ----------------------------------------------------------------------------
package urbfc_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;

	localparam int RX_PTR_W = $clog2(RX_DEPTH);
	localparam int TX_PTR_W = $clog2(TX_DEPTH);

	// width for comparing free receive space against the 8-bit mark
	localparam int RX_CMP_W = (RX_PTR_W > 8) ? RX_PTR_W : 8;

	// operation codes
	localparam logic [2:0] OP_RX_BYTE = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_PUT     = 3'd2;
	localparam logic [2:0] OP_TX_RDY  = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// configuration register indexes
	localparam int          CFG_IDX_W     = 1;
	localparam logic [0:0]  REG_FLOW_EN   = 1'b0;
	localparam logic [0:0]  REG_LOW_WATER = 1'b1;
	localparam logic [7:0]  LOW_WATER_RST = 8'd16;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
		logic       cts_blocked;
	} item_in_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       read_valid;
		logic [7:0] line_byte;
		logic       line_valid;
		logic       put_accepted;
		logic       rx_dropped;
		logic       rts_asserted;
		logic       tx_complete;
		logic       tx_enabled;
		logic [7:0] rx_level;
		logic       tx_space_available;
	} item_out_t;

	function automatic logic [RX_PTR_W-1:0] rx_next(input logic [RX_PTR_W-1:0] p);
		logic [RX_PTR_W-1:0] n;
		if (p == RX_PTR_W'(RX_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + RX_PTR_W'(1);
		end
		return n;
	endfunction

	function automatic logic [TX_PTR_W-1:0] tx_next(input logic [TX_PTR_W-1:0] p);
		logic [TX_PTR_W-1:0] n;
		if (p == TX_PTR_W'(TX_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + TX_PTR_W'(1);
		end
		return n;
	endfunction

	// bytes held between read and write pointer, wrapping at RX_DEPTH
	function automatic logic [RX_PTR_W-1:0] rx_used(input logic [RX_PTR_W-1:0] wp,
	                                                input logic [RX_PTR_W-1:0] rp);
		logic [RX_PTR_W:0] t;
		t = {1'b0, wp} - {1'b0, rp};
		if (wp < rp) begin
			t = t + (RX_PTR_W+1)'(RX_DEPTH);
		end
		return t[RX_PTR_W-1:0];
	endfunction

endpackage

// ===== rtl/uart_ring_buffers_flow_control.sv =====
// ----------------------------------------------------------------------------
// uart_ring_buffers_flow_control: UART receive and transmit rings with RTS/CTS
// Two byte rings in block memory, pointer bookkeeping and flow-control flags.
// ----------------------------------------------------------------------------
// Each input beat carries one operation: store a line byte, read the oldest
// received byte, queue a byte for sending, service the transmitter, or clear
// both rings. Each ring keeps one slot free, so it holds up to depth minus one
// bytes. The block takes one beat per clock cycle while in_stall is low; each
// result beat passes through stage 1, which waits for the synchronous read
// port of the ring memories, and then the output register. Pointers, RTS and
// the transmit enable are updated at the accepting edge, so a following beat
// always sees them current; a byte returned by a read or a send was always
// written at an earlier edge than the one that reads it.
// Configuration writes are always taken (cfg_ready is tied high) and should be
// issued only while no beat is in flight.
// ----------------------------------------------------------------------------
module uart_ring_buffers_flow_control (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  urbfc_pkg::item_in_t            in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output urbfc_pkg::item_out_t           out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [urbfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	import urbfc_pkg::*;

	// ring pointers and flags
	logic [RX_PTR_W-1:0] rx_wp_q, rx_rp_q, rx_wp_d, rx_rp_d;
	logic [TX_PTR_W-1:0] tx_wp_q, tx_rp_q, tx_wp_d, tx_rp_d;
	logic                rts_q, rts_d;
	logic                tx_en_q, tx_en_d;

	// configuration
	logic                flow_en_q;
	logic [7:0]          low_water_q;

	// memory controls
	logic                rx_we, tx_we;
	logic [7:0]          rx_rdata, tx_rdata;
	logic [RX_PTR_W-1:0] rx_free;

	// stage 1 waits for the read data, then the output register
	logic                valid_s1;
	item_out_t           res_d, res_s1;
	item_out_t           res_out;
	logic                out_valid_q;
	item_out_t           out_data_q;

	logic                in_accept;
	logic                s1_move;

	// move stage 1 on whenever the output register is free or being taken
	assign s1_move   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// per-operation update of pointers and flags
	always_comb begin
		rx_wp_d = rx_wp_q;
		rx_rp_d = rx_rp_q;
		tx_wp_d = tx_wp_q;
		tx_rp_d = tx_rp_q;
		rts_d   = rts_q;
		tx_en_d = tx_en_q;
		rx_we   = 1'b0;
		tx_we   = 1'b0;
		res_d   = '0;
		rx_free = '0;
		unique case (in_data.operation)
			OP_RX_BYTE: begin
				if (rx_next(rx_wp_q) != rx_rp_q) begin
					rx_we   = 1'b1;
					rx_wp_d = rx_next(rx_wp_q);
				end else begin
					res_d.rx_dropped = 1'b1;
				end
				// low-water test runs even when the byte is dropped
				rx_free = RX_PTR_W'(RX_DEPTH - 1) - rx_used(rx_wp_d, rx_rp_q);
				if (flow_en_q && (RX_CMP_W'(rx_free) <= RX_CMP_W'(low_water_q))) begin
					rts_d = 1'b0;
				end
			end
			OP_READ: begin
				if (rx_wp_q == rx_rp_q) begin
					if (flow_en_q) begin
						rts_d = 1'b1;
					end
				end else begin
					res_d.read_valid = 1'b1;
					rx_rp_d          = rx_next(rx_rp_q);
				end
			end
			OP_PUT: begin
				if (tx_next(tx_wp_q) != tx_rp_q) begin
					tx_we              = 1'b1;
					tx_wp_d            = tx_next(tx_wp_q);
					tx_en_d            = 1'b1;
					res_d.put_accepted = 1'b1;
				end
			end
			OP_TX_RDY: begin
				if (tx_en_q) begin
					if (tx_wp_q == tx_rp_q) begin
						tx_en_d           = 1'b0;
						res_d.tx_complete = 1'b1;
					end else if (flow_en_q && in_data.cts_blocked) begin
						// hold off: keep the pointers, stop servicing
						tx_en_d = 1'b0;
					end else begin
						res_d.line_valid = 1'b1;
						tx_rp_d          = tx_next(tx_rp_q);
					end
				end
			end
			OP_CLEAR: begin
				rx_wp_d = '0;
				rx_rp_d = '0;
				tx_wp_d = '0;
				tx_rp_d = '0;
			end
			default: begin
			end
		endcase
		res_d.rts_asserted       = rts_d;
		res_d.tx_enabled         = tx_en_d;
		res_d.rx_level           = 8'(rx_used(rx_wp_d, rx_rp_d));
		res_d.tx_space_available = (tx_next(tx_wp_d) != tx_rp_d);
	end

	// receive ring: written at the write pointer, read at the read pointer
	urbfc_ram #(
		.DEPTH(RX_DEPTH),
		.WIDTH(8)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we && in_accept),
		.waddr(rx_wp_q),
		.wdata(in_data.data_byte),
		.re   (in_accept),
		.raddr(rx_rp_q),
		.rdata(rx_rdata)
	);

	// transmit ring
	urbfc_ram #(
		.DEPTH(TX_DEPTH),
		.WIDTH(8)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we && in_accept),
		.waddr(tx_wp_q),
		.wdata(in_data.data_byte),
		.re   (in_accept),
		.raddr(tx_rp_q),
		.rdata(tx_rdata)
	);

	// control state, updated on accepted beats and configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q     <= '0;
			rx_rp_q     <= '0;
			tx_wp_q     <= '0;
			tx_rp_q     <= '0;
			rts_q       <= 1'b1;
			tx_en_q     <= 1'b0;
			flow_en_q   <= 1'b0;
			low_water_q <= LOW_WATER_RST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				rx_wp_q <= rx_wp_d;
				rx_rp_q <= rx_rp_d;
				tx_wp_q <= tx_wp_d;
				tx_rp_q <= tx_rp_d;
				rts_q   <= rts_d;
				tx_en_q <= tx_en_d;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FLOW_EN:   flow_en_q   <= cfg_data[0];
					REG_LOW_WATER: low_water_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// stage 1 occupancy
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			// output register occupancy
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// merge the ring bytes into the stage 1 result
	always_comb begin
		res_out           = res_s1;
		res_out.read_byte = res_s1.read_valid ? rx_rdata : 8'd0;
		res_out.line_byte = res_s1.line_valid ? tx_rdata : 8'd0;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res_d;
		end
		if (s1_move) begin
			out_data_q <= res_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/urbfc_ram.sv =====
// ----------------------------------------------------------------------------
// urbfc_ram: simple dual-port byte store
// One write port, one read port with enable; read data registered.
// ----------------------------------------------------------------------------
module urbfc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/urbfc_checker.sv =====
// ----------------------------------------------------------------------------
// urbfc_checker: port-level assertions for the UART ring buffers
// Watches the beat channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module urbfc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input urbfc_pkg::item_out_t out_data
);

	import urbfc_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// input back-pressure only arises from a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// data bytes are zero unless flagged
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.read_valid || out_data.read_byte == 8'd0) &&
		              (out_data.line_valid || out_data.line_byte == 8'd0))
		else $error("unflagged data byte is non-zero");

	// an accepted put leaves the transmitter enabled
	a_put_enables: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.put_accepted |-> out_data.tx_enabled)
		else $error("accepted put without transmit enable");

	// completion means an empty transmit ring and a disabled transmitter
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_complete |->
			!out_data.tx_enabled && !out_data.line_valid && out_data.tx_space_available)
		else $error("inconsistent transmit completion");

endmodule

bind uart_ring_buffers_flow_control urbfc_checker u_urbfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
